// ----- rtl/core/vksa_pkg.sv -----
// ----------------------------------------------------------------------------
// vksa_pkg
// Shared widths, status codes and control types of the versioned key slot
// allocator.
// ----------------------------------------------------------------------------
package vksa_pkg;

    localparam int KEY_W             = 6;
    localparam int HANDLE_W          = 64;
    localparam int VER_W             = 32;
    localparam int STATUS_W          = 2;
    localparam int MAX_SLOTS         = 64;
    localparam int TABLE_DEPTH_DEF   = 64;

    localparam logic CMD_CREATE = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STS_BAD_KEY = 2'd2;

    typedef struct packed {
        logic capture;
        logic commit;
    } vksa_ctl_t;

    function automatic int slot_count(input int depth);
        return (depth < MAX_SLOTS) ? depth : MAX_SLOTS;
    endfunction

endpackage

// ----- rtl/core/vksa_req_if.sv -----
// ----------------------------------------------------------------------------
// vksa_req_if
// Request channel: one command word with its key and destructor handle.
// ----------------------------------------------------------------------------
interface vksa_req_if;
    import vksa_pkg::*;

    logic                valid;
    logic                ready;
    logic                cmd;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] destructor_handle;

    modport source (output valid, output cmd, output key, output destructor_handle,
                    input ready);
    modport sink   (input valid, input cmd, input key, input destructor_handle,
                    output ready);
endinterface

// ----- rtl/core/vksa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// vksa_rsp_if
// Response channel: one result word with status, key and slot version.
// ----------------------------------------------------------------------------
interface vksa_rsp_if;
    import vksa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    new_key;
    logic [VER_W-1:0]    slot_version;

    modport source (output valid, output status, output new_key, output slot_version,
                    input ready);
    modport sink   (input valid, input status, input new_key, input slot_version,
                    output ready);
endinterface

// ----- rtl/core/vksa_ctrl.sv -----
// ----------------------------------------------------------------------------
// vksa_ctrl
// Controller: accepts one request word while the slot tables are read, then
// commits the update once the response register is free.
// ----------------------------------------------------------------------------
module vksa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output vksa_pkg::vksa_ctl_t ctl
);
    import vksa_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   out_free;

    assign out_free    = !rsp_valid_reg || rsp_ready;
    assign req_ready   = (state_reg == ST_IDLE);
    assign ctl.capture = req_ready && req_valid;
    assign ctl.commit  = (state_reg == ST_EXEC) && out_free;
    assign rsp_valid   = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctl.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ----- rtl/core/vksa_dp.sv -----
// ----------------------------------------------------------------------------
// vksa_dp
// Datapath: free list head, active and touched flags, link, version and
// handle memories, request latch and response register.
// ----------------------------------------------------------------------------
module vksa_dp #(
    parameter int TABLE_DEPTH = vksa_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  vksa_pkg::vksa_ctl_t           ctl,
    input  logic                          cmd,
    input  logic [vksa_pkg::KEY_W-1:0]    key,
    input  logic [vksa_pkg::HANDLE_W-1:0] destructor_handle,
    output logic [vksa_pkg::STATUS_W-1:0] status,
    output logic [vksa_pkg::KEY_W-1:0]    new_key,
    output logic [vksa_pkg::VER_W-1:0]    slot_version
);
    import vksa_pkg::*;

    localparam int SLOT_COUNT = slot_count(TABLE_DEPTH);
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int HEAD_W     = $clog2(SLOT_COUNT + 1);
    localparam logic [HEAD_W-1:0]  LIST_END  = HEAD_W'(SLOT_COUNT);
    localparam logic [KEY_W:0]     KEY_LIMIT = (KEY_W + 1)'(SLOT_COUNT);

    logic [HEAD_W-1:0]   link_mem [SLOT_COUNT];
    logic [VER_W-1:0]    ver_mem  [SLOT_COUNT];
    logic [HANDLE_W-1:0] hdl_mem  [SLOT_COUNT];

    logic [HEAD_W-1:0]     head_reg;
    logic [HEAD_W-1:0]     head_next;
    logic [SLOT_COUNT-1:0] active_reg;
    logic [SLOT_COUNT-1:0] active_next;
    logic [SLOT_COUNT-1:0] used_reg;
    logic [SLOT_COUNT-1:0] used_next;

    logic                  op_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [HANDLE_W-1:0]   handle_reg;
    logic                  fail_reg;
    logic [STATUS_W-1:0]   fail_code_reg;
    logic                  used_rd_reg;
    logic [HEAD_W-1:0]     link_rd_reg;
    logic [VER_W-1:0]      ver_rd_reg;

    logic [STATUS_W-1:0]   status_reg;
    logic [KEY_W-1:0]      new_key_reg;
    logic [VER_W-1:0]      slot_version_reg;

    logic                  key_big;
    logic                  head_end;
    logic                  fail_now;
    logic [STATUS_W-1:0]   fail_code_now;
    logic [SLOT_W-1:0]     addr;
    logic [HEAD_W-1:0]     link_val;
    logic [VER_W-1:0]      ver_val;
    logic [VER_W-1:0]      ver_bumped;
    logic                  do_create;
    logic                  do_delete;

    assign key_big  = ({1'b0, key} >= KEY_LIMIT);
    assign head_end = (head_reg >= LIST_END);

    always_comb
    begin
        addr          = '0;
        fail_now      = 1'b0;
        fail_code_now = STS_OK;
        if (cmd == CMD_CREATE)
        begin
            if (head_end)
            begin
                fail_now      = 1'b1;
                fail_code_now = STS_FULL;
            end
            else
            begin
                addr = head_reg[SLOT_W-1:0];
            end
        end
        else
        begin
            if (key_big)
            begin
                fail_now      = 1'b1;
                fail_code_now = STS_BAD_KEY;
            end
            else
            begin
                addr = key[SLOT_W-1:0];
                if (!active_reg[addr])
                begin
                    fail_now      = 1'b1;
                    fail_code_now = STS_BAD_KEY;
                end
            end
        end
    end

    assign link_val   = used_rd_reg ? link_rd_reg : (HEAD_W'(slot_reg) + HEAD_W'(1));
    assign ver_val    = used_rd_reg ? ver_rd_reg : VER_W'(1);
    assign ver_bumped = ver_val + VER_W'(1);
    assign do_create  = ctl.commit && !fail_reg && (op_reg == CMD_CREATE);
    assign do_delete  = ctl.commit && !fail_reg && (op_reg == CMD_DELETE);

    always_comb
    begin
        head_next   = head_reg;
        active_next = active_reg;
        used_next   = used_reg;
        if (do_create)
        begin
            head_next             = link_val;
            active_next[slot_reg] = 1'b1;
        end
        else if (do_delete)
        begin
            head_next             = HEAD_W'(slot_reg);
            active_next[slot_reg] = 1'b0;
            used_next[slot_reg]   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            active_reg <= '0;
            used_reg   <= '0;
        end
        else
        begin
            head_reg   <= head_next;
            active_reg <= active_next;
            used_reg   <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            op_reg        <= cmd;
            slot_reg      <= addr;
            handle_reg    <= destructor_handle;
            fail_reg      <= fail_now;
            fail_code_reg <= fail_code_now;
            used_rd_reg   <= used_reg[addr];
            link_rd_reg   <= link_mem[addr];
            ver_rd_reg    <= ver_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_delete)
        begin
            link_mem[slot_reg] <= head_reg;
            ver_mem[slot_reg]  <= ver_bumped;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_create)
        begin
            hdl_mem[slot_reg] <= handle_reg;
        end
        else if (do_delete)
        begin
            hdl_mem[slot_reg] <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            if (fail_reg)
            begin
                status_reg       <= fail_code_reg;
                new_key_reg      <= '0;
                slot_version_reg <= '0;
            end
            else if (op_reg == CMD_CREATE)
            begin
                status_reg       <= STS_OK;
                new_key_reg      <= KEY_W'(slot_reg);
                slot_version_reg <= ver_val;
            end
            else
            begin
                status_reg       <= STS_OK;
                new_key_reg      <= '0;
                slot_version_reg <= ver_bumped;
            end
        end
    end

    assign status       = status_reg;
    assign new_key      = new_key_reg;
    assign slot_version = slot_version_reg;

endmodule

// ----- rtl/core/versioned_key_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// versioned_key_slot_allocator
// Fixed table of key slots handed out from a last-in first-out free list.
//
// A request word on req carries a command (create or delete), a key for
// delete and a destructor handle for create. Each request gives exactly one
// response word on rsp with a status, the new key on a successful create and
// the slot version after the operation.
// Requests are taken one at a time: the slot tables are read when a request
// is accepted and updated when its update is committed, which also loads the
// response register; no new request is accepted before that commit. The
// single read and write port of the link and version memories sets this
// one-at-a-time order.
// When the receiver stalls, the finished word waits in the response register
// while the next request is still accepted; that request then holds in its
// update cycle until the response register is free.
// Reset empties the response register, puts every slot on the free list in
// index order, clears all active marks and sets every version to one. No
// clearing pass is needed.
// ----------------------------------------------------------------------------
module versioned_key_slot_allocator #(
    parameter int TABLE_DEPTH = vksa_pkg::TABLE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    vksa_req_if.sink   req,
    vksa_rsp_if.source rsp
);
    import vksa_pkg::*;

    vksa_ctl_t ctl;

    vksa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .ctl       (ctl)
    );

    vksa_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctl               (ctl),
        .cmd               (req.cmd),
        .key               (req.key),
        .destructor_handle (req.destructor_handle),
        .status            (rsp.status),
        .new_key           (rsp.new_key),
        .slot_version      (rsp.slot_version)
    );

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("A second request word was accepted during an update.");

    a_commit_fills_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |=> rsp.valid)
        else $error("A committed update did not produce a response word.");

    a_fail_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != STS_OK)) |->
            ((rsp.new_key == '0) && (rsp.slot_version == '0)))
        else $error("A rejected request returned a nonzero key or version.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> ((rsp.status == STS_OK) || (rsp.status == STS_FULL) ||
                       (rsp.status == STS_BAD_KEY)))
        else $error("The response word carries an undefined status.");

endmodule
